// ----- rtl/core/aac_pkg.sv -----
// Shared types and constants of the AAC RTP depacketizer.
`timescale 1ns / 1ps

package aac_pkg;

   localparam int MAX_AU_HEADERS_DEF = 16;
   localparam int ADTS_LEN_DEF       = 7;

   // frames * 1024 samples * 1000 ms per second
   localparam logic [19:0] DTS_SCALE = 20'd1024000;
   localparam int          QUOT_W    = 36;
   localparam logic [5:0]  DIV_STEPS = 6'd36;

   localparam logic [7:0] ADTS_SYNC_HI  = 8'hFF;
   localparam logic [3:0] ADTS_SYNC_NIB = 4'hF;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_COMMIT = 2'd1,
      KIND_ABORT  = 2'd2
   } kind_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic div_write;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic div_need;
      logic div_busy;
   } dp_status_type;

endpackage

// ----- rtl/core/aac_rtp_depacketizer.sv -----
// AAC-hbr RTP depacketizer top level.
//
// Requests carry one RTP payload byte with its packet metadata on the req_
// valid/ready channel. Results leave on the rsp_ channel: an AU data byte, the
// last AU byte with commit (length, dts, ADTS-prefix flag), or an abort of the
// AU in progress. The csr_ channel writes the sample rate; csr_ready is always
// high and writes belong between requests.
// One request is in flight at a time: a request is loaded in ST_IDLE and
// evaluated in ST_EXEC once the result register is free, which writes its
// result into the output register; the next request is taken back in ST_IDLE.
// When an unfragmented AU starts with a nonzero frame offset, its dts goes
// through a shift-subtract divider (a multiply step, then 36 quotient steps);
// the next request is not taken until the divider is done.
// A stalled receiver holds the result register; the next request is taken,
// and its evaluation waits until the register frees.
// Synchronous reset clears the stream tracking and the sample rate and empties
// the output register; the AU-header table is not cleared, every entry being
// written before it is read within a packet.
`timescale 1ns / 1ps

module aac_rtp_depacketizer #(
   parameter int MAX_AU_HEADERS = aac_pkg::MAX_AU_HEADERS_DEF,
   parameter int ADTS_LEN       = aac_pkg::ADTS_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_first_of_packet,
   input  logic        req_last_of_packet,
   input  logic [15:0] req_payload_length,
   input  logic [15:0] req_sequence_number,
   input  logic [31:0] req_rtp_timestamp,
   input  logic [31:0] req_source_id,
   input  logic        req_marker,
   input  logic [39:0] req_stamp_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_au_byte,
   output logic [12:0] rsp_au_length,
   output logic [39:0] rsp_au_dts,
   output logic        rsp_adts_prefix,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [17:0] csr_rate_hz
);

   aac_pkg::ctrl_cmd_type  cmd;
   aac_pkg::dp_status_type status;

   aac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   aac_dp #(
      .MAX_AU_HEADERS (MAX_AU_HEADERS),
      .ADTS_LEN       (ADTS_LEN)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_payload_byte    (req_payload_byte),
      .req_first_of_packet (req_first_of_packet),
      .req_last_of_packet  (req_last_of_packet),
      .req_payload_length  (req_payload_length),
      .req_sequence_number (req_sequence_number),
      .req_rtp_timestamp   (req_rtp_timestamp),
      .req_source_id       (req_source_id),
      .req_marker          (req_marker),
      .req_stamp_ms        (req_stamp_ms),
      .csr_valid           (csr_valid),
      .csr_rate_hz         (csr_rate_hz),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_au_byte         (rsp_au_byte),
      .rsp_au_length       (rsp_au_length),
      .rsp_au_dts          (rsp_au_dts),
      .rsp_adts_prefix     (rsp_adts_prefix)
   );

   assign csr_ready = 1'b1;

endmodule

// ----- rtl/core/aac_div.sv -----
// Multi-cycle unit for frames * 1024000 / rate, one quotient bit per cycle.
`timescale 1ns / 1ps

module aac_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [15:0]               offset,
   input  logic [17:0]               divisor,
   output logic                      busy,
   output logic [aac_pkg::QUOT_W-1:0] quotient
);

   logic        mul_ff;
   logic        run_ff;
   logic [5:0]  cnt_ff;
   logic [15:0] op_ff;
   logic [17:0] dv_ff;
   logic [aac_pkg::QUOT_W-1:0] num_ff;
   logic [17:0] rem_ff;
   logic [18:0] rem_sh;
   logic        ge;
   logic [17:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, num_ff[aac_pkg::QUOT_W-1]};
      ge     = rem_sh >= {1'b0, dv_ff};
      rem_in = ge ? 18'(rem_sh - {1'b0, dv_ff}) : rem_sh[17:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= 1'b0;
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         mul_ff <= 1'b1;
         run_ff <= 1'b0;
      end else if (mul_ff) begin
         mul_ff <= 1'b0;
         run_ff <= 1'b1;
         cnt_ff <= aac_pkg::DIV_STEPS;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff <= offset;
         dv_ff <= divisor;
      end else if (mul_ff) begin
         num_ff <= aac_pkg::QUOT_W'(op_ff) * aac_pkg::QUOT_W'(aac_pkg::DTS_SCALE);
         rem_ff <= '0;
      end else if (run_ff) begin
         // shift the next dividend bit out at the top, the quotient bit in at the bottom
         num_ff <= {num_ff[aac_pkg::QUOT_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign busy     = mul_ff | run_ff;
   assign quotient = num_ff;

endmodule

// ----- rtl/core/aac_dp.sv -----
// Datapath: stream state, AU-header table, per-byte evaluation and result register.
`timescale 1ns / 1ps

module aac_dp #(
   parameter int MAX_AU_HEADERS = aac_pkg::MAX_AU_HEADERS_DEF,
   parameter int ADTS_LEN       = aac_pkg::ADTS_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  aac_pkg::ctrl_cmd_type cmd,
   output aac_pkg::dp_status_type status,
   input  logic [7:0]            req_payload_byte,
   input  logic                  req_first_of_packet,
   input  logic                  req_last_of_packet,
   input  logic [15:0]           req_payload_length,
   input  logic [15:0]           req_sequence_number,
   input  logic [31:0]           req_rtp_timestamp,
   input  logic [31:0]           req_source_id,
   input  logic                  req_marker,
   input  logic [39:0]           req_stamp_ms,
   input  logic                  csr_valid,
   input  logic [17:0]           csr_rate_hz,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_au_byte,
   output logic [12:0]           rsp_au_length,
   output logic [39:0]           rsp_au_dts,
   output logic                  rsp_adts_prefix
);

   localparam int AU_W = $clog2(MAX_AU_HEADERS + 1);
   localparam int AW   = (MAX_AU_HEADERS > 1) ? $clog2(MAX_AU_HEADERS) : 1;

   typedef enum logic [2:0] {
      PH_IDLE, PH_LEN, PH_HDR, PH_DATA, PH_SKIP
   } phase_type;

   // latched request
   logic [7:0]  it_byte;
   logic        it_first, it_last, it_mark;
   logic [15:0] it_len, it_seq;
   logic [31:0] it_ts, it_src;
   logic [39:0] it_stamp;

   logic [15:0] hdr_mem [MAX_AU_HEADERS];
   logic [15:0] rd_ff;
   logic [AW-1:0] rd_addr;

   phase_type   phase_ff, phase_in, ph_mid;
   logic        have_ff, have_in;
   logic [15:0] pseq_ff, pseq_in;
   logic [31:0] pts_ff, pts_in, psrc_ff, psrc_in;
   logic [12:0] psize_ff, psize_in;
   logic [2:0]  pidx_ff, pidx_in;
   logic        drop_ff, drop_in;
   logic [12:0] fill_ff, fill_in;
   logic [39:0] pdts_ff, pdts_in;
   logic [15:0] lead_ff, lead_in, lead_cur;
   logic [15:0] pp_ff, pp_in;
   logic [11:0] total_ff, total_in;
   logic [AU_W-1:0] cur_ff, cur_in;
   logic [15:0] off_ff, off_in;
   logic [7:0]  lhigh_ff, lhigh_in;
   logic [7:0]  hi_ff, hi_in;
   logic [12:0] ausize_ff, ausize_in;
   logic [17:0] sr_ff;

   logic        out_valid_ff;
   logic [1:0]  out_kind_ff;
   logic [7:0]  out_byte_ff;
   logic [12:0] out_len_ff;
   logic [39:0] out_dts_ff;
   logic        out_adts_ff;

   logic        res_valid;
   aac_pkg::kind_type res_kind;
   logic [7:0]  res_byte;
   logic [12:0] res_len;
   logic [39:0] res_dts;
   logic        res_adts;

   logic        abort_c, data_c, commit_c, disc, sa_disc, div_need;
   logic        same_src, same_ts;
   logic [15:0] dseq, pos, bits, k;
   logic [11:0] count;
   logic [14:0] e;
   logic        sa_call;
   logic [AU_W-1:0] sa_au;
   logic [15:0] sa_hdr;
   logic [16:0] sa_first, rem17;
   logic [15:0] remaining;
   logic [12:0] size;
   logic [2:0]  idx;
   logic        mem_we;
   logic [AW-1:0] mem_wa;

   logic        div_busy;
   logic [aac_pkg::QUOT_W-1:0] quot;

   always_comb begin
      phase_in = phase_ff;  have_in = have_ff;  pseq_in = pseq_ff;
      pts_in = pts_ff;  psrc_in = psrc_ff;  psize_in = psize_ff;
      pidx_in = pidx_ff;  drop_in = drop_ff;  fill_in = fill_ff;
      pdts_in = pdts_ff;  lead_in = lead_ff;  pp_in = pp_ff;
      total_in = total_ff;  cur_in = cur_ff;  off_in = off_ff;
      lhigh_in = lhigh_ff;  hi_in = hi_ff;  ausize_in = ausize_ff;
      abort_c = 1'b0;  data_c = 1'b0;  commit_c = 1'b0;
      disc = 1'b0;  sa_disc = 1'b0;  div_need = 1'b0;
      res_len = '0;  res_dts = '0;  res_adts = 1'b0;
      same_src = 1'b0;  same_ts = 1'b0;  dseq = '0;
      bits = '0;  count = '0;  k = '0;  e = '0;
      sa_call = 1'b0;  sa_au = cur_ff;  sa_hdr = rd_ff;  sa_first = '0;
      rem17 = '0;  remaining = '0;  size = '0;  idx = '0;
      mem_we = 1'b0;  mem_wa = '0;  lead_cur = lead_ff;

      if (it_first) begin
         // drop an unfragmented AU left half emitted
         if (fill_ff != '0 && psize_ff == '0) begin
            abort_c = 1'b1;
            fill_in = '0;  lead_in = '0;  psize_in = '0;
         end
         pp_in    = '0;
         same_src = have_ff && it_src == psrc_ff;
         same_ts  = same_src && it_ts == pts_ff;
         dseq     = it_seq - pseq_ff;
         if (same_ts && (dseq == '0 || dseq[15])) begin
            phase_in = PH_SKIP;
         end else begin
            if (!same_ts) begin
               if (psize_in != '0) begin
                  abort_c = abort_c | (fill_in != '0);
                  fill_in = '0;  lead_in = '0;  psize_in = '0;
               end
               drop_in = 1'b0;
            end else if (it_seq != 16'(pseq_ff + 16'd1)) begin
               abort_c = abort_c | (fill_in != '0);
               fill_in = '0;  lead_in = '0;  psize_in = '0;
               drop_in = 1'b1;
            end
            have_in = 1'b1;
            pseq_in = it_seq;
            pts_in  = it_ts;
            psrc_in = it_src;
            if (drop_in) begin
               phase_in = PH_SKIP;
            end else if (it_len < 16'd2) begin
               disc     = 1'b1;
               phase_in = PH_SKIP;
            end else begin
               phase_in = PH_LEN;
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         if (pp_ff != 16'hFFFF) begin
            pp_in = pp_ff + 16'd1;
         end
      end
      pos    = pp_in;
      ph_mid = phase_in;

      if ((ph_mid == PH_LEN || ph_mid == PH_HDR || ph_mid == PH_DATA) && pos < it_len) begin
         if (it_last && ({1'b0, pos} + 17'd1) < {1'b0, it_len}) begin
            disc = 1'b1;
         end else begin
            unique case (ph_mid)
               PH_LEN: begin
                  if (pos == '0) begin
                     lhigh_in = it_byte;
                  end else begin
                     bits  = {lhigh_ff, it_byte};
                     count = bits[15:4];
                     if (count == '0 || bits[3:0] != '0 ||
                         {1'b0, count} > 13'(MAX_AU_HEADERS) ||
                         16'(it_len - 16'd2) < {3'b0, count, 1'b0} ||
                         (count > 12'd1 && sr_ff == '0)) begin
                        disc = 1'b1;
                     end else begin
                        total_in = count;
                        cur_in   = '0;
                        off_in   = '0;
                        phase_in = PH_HDR;
                     end
                  end
               end
               PH_HDR: begin
                  k = pos - 16'd2;
                  e = k[15:1];
                  if (!k[0]) begin
                     hi_in = it_byte;
                  end else if ({1'b0, e} < 16'(MAX_AU_HEADERS)) begin
                     mem_we = 1'b1;
                     mem_wa = e[AW-1:0];
                  end
                  if (pos == {3'b0, total_ff, 1'b1}) begin
                     sa_call  = 1'b1;
                     sa_au    = cur_ff;
                     // the single header is completed by this very byte
                     sa_hdr   = (total_ff == 12'd1) ? {hi_ff, it_byte} : rd_ff;
                     sa_first = {1'b0, pos} + 17'd1;
                  end
               end
               PH_DATA: begin
                  data_c = 1'b1;
                  if (fill_ff == '0) begin
                     lead_cur = {it_byte, 8'h00};
                  end else if (fill_ff == 13'd1) begin
                     lead_cur = {lead_ff[15:8], it_byte};
                  end
                  lead_in = lead_cur;
                  fill_in = fill_ff + 13'd1;
                  if (fill_in == ausize_ff) begin
                     commit_c = 1'b1;
                     res_len  = ausize_ff;
                     res_dts  = pdts_ff;
                     res_adts = ausize_ff > 13'(ADTS_LEN) &&
                                lead_cur[15:8] == aac_pkg::ADTS_SYNC_HI &&
                                lead_cur[7:4] == aac_pkg::ADTS_SYNC_NIB;
                     fill_in  = '0;
                     lead_in  = '0;
                     psize_in = '0;
                     if (psize_ff != '0) begin
                        phase_in = PH_SKIP;
                     end else begin
                        cur_in = cur_ff + 1'b1;
                        if (13'(cur_in) < {1'b0, total_ff}) begin
                           sa_call  = 1'b1;
                           sa_au    = cur_in;
                           sa_hdr   = rd_ff;
                           sa_first = {1'b0, pos} + 17'd1;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      // evaluate the AU at sa_au, its first data byte at sa_first
      if (sa_call) begin
         rem17     = {1'b0, it_len} - sa_first;
         remaining = (sa_first < {1'b0, it_len}) ? rem17[15:0] : '0;
         if (13'(sa_au) >= 13'(MAX_AU_HEADERS)) begin
            sa_disc = 1'b1;
         end else begin
            size = sa_hdr[15:3];
            idx  = sa_hdr[2:0];
            if (sa_au != '0) begin
               off_in = off_in + 16'(idx) + 16'd1;
            end
            if (size == '0) begin
               sa_disc = 1'b1;
            end else if (psize_in != '0) begin
               if (total_in != 12'd1 || size != psize_in || idx != pidx_in ||
                   fill_in >= size || {1'b0, remaining} > {4'b0, 13'(size - fill_in)}) begin
                  sa_disc = 1'b1;
               end else if (({4'b0, fill_in} + {1'b0, remaining}) < {4'b0, size} &&
                            it_mark) begin
                  sa_disc = 1'b1;
               end else begin
                  ausize_in = size;
                  phase_in  = (remaining != '0) ? PH_DATA : PH_SKIP;
               end
            end else begin
               if (off_in != '0 && sr_ff != '0) begin
                  div_need = 1'b1;
               end else begin
                  pdts_in = it_stamp;
               end
               if (remaining < {3'b0, size}) begin
                  if (total_in != 12'd1 || remaining == '0 || it_mark) begin
                     sa_disc = 1'b1;
                  end else begin
                     psize_in = size;
                     pidx_in  = idx;
                  end
               end
               if (!sa_disc) begin
                  ausize_in = size;
                  phase_in  = PH_DATA;
               end
            end
         end
      end

      if (disc || sa_disc) begin
         abort_c  = abort_c | (fill_in != '0);
         fill_in  = '0;
         lead_in  = '0;
         psize_in = '0;
         drop_in  = 1'b1;
         phase_in = PH_SKIP;
      end
      if (it_last) begin
         phase_in = PH_IDLE;
      end

      res_valid = data_c | abort_c;
      if (data_c) begin
         res_kind = commit_c ? aac_pkg::KIND_COMMIT : aac_pkg::KIND_DATA;
         res_byte = it_byte;
      end else begin
         res_kind = aac_pkg::KIND_ABORT;
         res_byte = '0;
         res_len  = '0;
         res_dts  = '0;
         res_adts = 1'b0;
      end
   end

   assign rd_addr = (phase_ff == PH_DATA) ? AW'(AU_W'(cur_ff + 1'b1)) : AW'(cur_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         it_byte  <= req_payload_byte;
         it_first <= req_first_of_packet;
         it_last  <= req_last_of_packet;
         it_len   <= req_payload_length;
         it_seq   <= req_sequence_number;
         it_ts    <= req_rtp_timestamp;
         it_src   <= req_source_id;
         it_mark  <= req_marker;
         it_stamp <= req_stamp_ms;
         rd_ff    <= hdr_mem[rd_addr];
      end
      if (cmd.exec && mem_we) begin
         hdr_mem[mem_wa] <= {hi_ff, it_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;  have_ff <= 1'b0;  pseq_ff <= '0;
         pts_ff <= '0;  psrc_ff <= '0;  psize_ff <= '0;  pidx_ff <= '0;
         drop_ff <= 1'b0;  fill_ff <= '0;  pdts_ff <= '0;  lead_ff <= '0;
         pp_ff <= '0;  total_ff <= '0;  cur_ff <= '0;  off_ff <= '0;
         lhigh_ff <= '0;  hi_ff <= '0;  ausize_ff <= '0;  sr_ff <= '0;
      end else begin
         if (csr_valid) begin
            sr_ff <= csr_rate_hz;
         end
         if (cmd.exec) begin
            phase_ff <= phase_in;  have_ff <= have_in;  pseq_ff <= pseq_in;
            pts_ff <= pts_in;  psrc_ff <= psrc_in;  psize_ff <= psize_in;
            pidx_ff <= pidx_in;  drop_ff <= drop_in;  fill_ff <= fill_in;
            pdts_ff <= pdts_in;  lead_ff <= lead_in;  pp_ff <= pp_in;
            total_ff <= total_in;  cur_ff <= cur_in;  off_ff <= off_in;
            lhigh_ff <= lhigh_in;  hi_ff <= hi_in;  ausize_ff <= ausize_in;
         end else if (cmd.div_write) begin
            pdts_ff <= it_stamp + {4'b0, quot};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.exec && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && res_valid) begin
         out_kind_ff <= res_kind;
         out_byte_ff <= res_byte;
         out_len_ff  <= res_len;
         out_dts_ff  <= res_dts;
         out_adts_ff <= res_adts;
      end
   end

   aac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && div_need),
      .offset   (off_in),
      .divisor  (sr_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.div_need = div_need;
   assign status.div_busy = div_busy;

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_au_byte     = out_byte_ff;
   assign rsp_au_length   = out_len_ff;
   assign rsp_au_dts      = out_dts_ff;
   assign rsp_adts_prefix = out_adts_ff;

endmodule

// ----- rtl/core/aac_ctrl.sv -----
// Controller: sequences request load, evaluation and the dts divider.
`timescale 1ns / 1ps

module aac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  aac_pkg::dp_status_type status,
   output aac_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE, ST_EXEC, ST_DIV
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.exec      = 1'b0;
      cmd.div_write = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register can take the outcome
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = status.div_need ? ST_DIV : ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               cmd.div_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule
